// ===== hdl/dqap_pkg.sv =====
// Constants and helpers for the dotted-quad address parser.
// No dependencies; imported by the interfaces and the top level.
`default_nettype none

package dqap_pkg;

  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned OCTETS   = 4;
  localparam int unsigned COUNT_W  = 3;

  localparam logic [CHAR_W-1:0] CHAR_DOT  = 8'h2E;  // '.'
  localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;  // '0'
  localparam logic [CHAR_W-1:0] CHAR_X    = 8'h78;  // 'x', lower case only

  localparam logic [COUNT_W-1:0] FIELDS_FULL = COUNT_W'(OCTETS);

  // Hex value of 0-9, a-f, A-F; anything else passes its own code.
  function automatic logic [CHAR_W-1:0] digit_value(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] v;
    v = c;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = c - 8'h57;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = c - 8'h37;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/dqap_if.sv =====
// Valid/ready channel interfaces for the parser: character in, address out.
// Depends on dqap_pkg for field widths.
`default_nettype none

interface dqap_text_if;
  import dqap_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] text_char;
  logic              end_of_text;

  modport source (output valid, output text_char, output end_of_text, input ready);
  modport sink   (input valid, input text_char, input end_of_text, output ready);
endinterface

interface dqap_addr_if;
  import dqap_pkg::*;
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] address;
  logic              complete;

  modport source (output valid, output address, output complete, input ready);
  modport sink   (input valid, input address, input complete, output ready);
endinterface

`default_nettype wire

// ===== hdl/dotted_quad_address_parser_top.sv =====
// Dotted-quad address parser: one character per beat, one address per string.
// Depends on dqap_pkg and the channel interfaces in dqap_if.sv.
//
//   channel  dir  payload                      beat
//   text     in   text_char[7:0], end_of_text  one character
//   result   out  address[31:0], complete      one parsed string
//
// One character per cycle unless a held result stalls input: the field state
// updates in the accepting cycle (a constant x10/x16 accumulate), and the last
// character's address lands in the result register, visible the next cycle.
// Reset (rst, synchronous) clears the field state and the result valid.
// A stalled result blocks input only while it is held and not taken.
`default_nettype none

module dotted_quad_address_parser_top (
  input  wire logic clk,
  input  wire logic rst,
  dqap_text_if.sink   text,
  dqap_addr_if.source result
);
  import dqap_pkg::*;

  logic [COUNT_W-1:0] field_count, field_count_next;
  logic [CHAR_W-1:0]  accumulator, accumulator_next;
  logic [1:0]         chars_in_field, chars_in_field_next;
  logic               leading_zero_seen, leading_zero_seen_next;
  logic               hex_mode, hex_mode_next;
  logic               inside_field, inside_field_next;
  logic [23:0]        finished_octets, finished_octets_next;

  logic [ADDR_W-1:0]  address_next;
  logic               complete_next;
  logic               accept;

  logic [CHAR_W-1:0]  c;
  logic [1:0]         chars_eff;
  logic               lz_eff, hex_eff;
  logic [CHAR_W-1:0]  acc_eff, acc_scaled;

  assign text.ready = !result.valid || result.ready;
  assign accept     = text.valid && text.ready;
  assign c          = text.text_char;

  always_comb begin
    field_count_next       = field_count;
    accumulator_next       = accumulator;
    chars_in_field_next    = chars_in_field;
    leading_zero_seen_next = leading_zero_seen;
    hex_mode_next          = hex_mode;
    inside_field_next      = inside_field;
    finished_octets_next   = finished_octets;
    chars_eff              = inside_field ? chars_in_field : 2'd0;
    lz_eff                 = inside_field && leading_zero_seen;
    hex_eff                = inside_field && hex_mode;
    acc_eff                = inside_field ? accumulator : '0;
    acc_scaled             = hex_eff ? {acc_eff[3:0], 4'b0000}
                                     : CHAR_W'({acc_eff[6:0], 1'b0} + {acc_eff[4:0], 3'b000});
    address_next           = '0;
    complete_next          = 1'b0;

    // character step
    if (field_count < FIELDS_FULL) begin
      if (c == CHAR_DOT) begin
        if (inside_field) begin
          if (field_count < FIELDS_FULL - 3'd1) begin
            finished_octets_next = {finished_octets[15:0], accumulator};
          end
          field_count_next  = field_count + 3'd1;
          inside_field_next = 1'b0;
        end
      end else begin
        inside_field_next = 1'b1;
        hex_mode_next     = hex_eff;
        if (chars_eff == 2'd1 && lz_eff && !hex_eff && c == CHAR_X) begin
          hex_mode_next    = 1'b1;
          accumulator_next = '0;
        end else begin
          accumulator_next = acc_scaled + digit_value(c);
        end
        leading_zero_seen_next = (chars_eff == 2'd0) ? (c == CHAR_ZERO) : lz_eff;
        chars_in_field_next    = (chars_eff == 2'd2) ? 2'd2 : chars_eff + 2'd1;
      end
    end

    // end of string: close an open field, then form the address
    if (inside_field_next && field_count_next < FIELDS_FULL) begin
      if (field_count_next < FIELDS_FULL - 3'd1) begin
        finished_octets_next = {finished_octets_next[15:0], accumulator_next};
      end
      // only the last-character path keeps these
      if (text.end_of_text) begin
        field_count_next  = field_count_next + 3'd1;
        inside_field_next = 1'b0;
      end
    end

    unique case (field_count_next)
      3'd0:    address_next = '0;
      3'd1:    address_next = {finished_octets_next[7:0], 24'h000000};
      3'd2:    address_next = {finished_octets_next[15:0], 16'h0000};
      3'd3:    address_next = {finished_octets_next, 8'h00};
      default: address_next = {finished_octets_next, accumulator_next};
    endcase
    complete_next = (field_count_next >= FIELDS_FULL);
  end

  // The closing shift above only matters on the last character; the stored
  // octets must not take it otherwise.
  logic [23:0] octets_keep;
  always_comb begin
    octets_keep = finished_octets_next;
    if (!text.end_of_text && inside_field_next && field_count_next < FIELDS_FULL - 3'd1) begin
      octets_keep = finished_octets_next >> 8;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      field_count       <= '0;
      accumulator       <= '0;
      chars_in_field    <= '0;
      leading_zero_seen <= 1'b0;
      hex_mode          <= 1'b0;
      inside_field      <= 1'b0;
      finished_octets   <= '0;
      result.valid      <= 1'b0;
    end else begin
      if (accept) begin
        if (text.end_of_text) begin
          field_count       <= '0;
          accumulator       <= '0;
          chars_in_field    <= '0;
          leading_zero_seen <= 1'b0;
          hex_mode          <= 1'b0;
          inside_field      <= 1'b0;
          finished_octets   <= '0;
        end else begin
          field_count       <= field_count_next;
          accumulator       <= accumulator_next;
          chars_in_field    <= chars_in_field_next;
          leading_zero_seen <= leading_zero_seen_next;
          hex_mode          <= hex_mode_next;
          inside_field      <= inside_field_next;
          finished_octets   <= octets_keep;
        end
      end
      if (accept && text.end_of_text) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && text.end_of_text) begin
      result.address  <= address_next;
      result.complete <= complete_next;
    end
  end

  // -- assertions
  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept && text.end_of_text |=> result.valid)
    else $error("no result after last character");

  a_no_spurious_result: assert property (@(posedge clk) disable iff (rst)
    !result.valid && !(accept && text.end_of_text) |=> !result.valid)
    else $error("result without last character");

  a_state_cleared: assert property (@(posedge clk) disable iff (rst)
    accept && text.end_of_text |=> field_count == '0 && !inside_field)
    else $error("field state not cleared after string");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    field_count <= FIELDS_FULL)
    else $error("field count out of range");

endmodule

`default_nettype wire
